FILE: hw/rtl/pixel_format_converter_assert.svh
// assertion macros used by the pixel format converter rtl
`ifndef PIXEL_FORMAT_CONVERTER_ASSERT_SVH
`define PIXEL_FORMAT_CONVERTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define PFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PFC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/pfc_pkg.sv
// types, constants and lookup tables for the pixel format converter
package pfc_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_ADDR_W    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;

  typedef enum logic [3:0] {
    FMT_A8R8G8B8 = 4'd0,
    FMT_X8R8G8B8 = 4'd1,
    FMT_R8G8B8   = 4'd2,
    FMT_A4R4G4B4 = 4'd3,
    FMT_R5G6B5   = 4'd4,
    FMT_A1R5G5B5 = 4'd5,
    FMT_R3G3B2   = 4'd6,
    FMT_L8       = 4'd7,
    FMT_A8       = 4'd8,
    FMT_P8       = 4'd9
  } fmt_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SOURCE_FORMAT       = 2'd0,
    CFG_TARGET_FORMAT       = 2'd1,
    CFG_PALETTE_ENTRY_BYTES = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE_PALETTE = 1'b0,
    CMD_CONVERT       = 1'b1
  } cmd_t;

  localparam logic [2:0] PAL_RGB_BYTES   = 3'd3;
  localparam logic [2:0] PAL_ARGB_BYTES  = 3'd4;
  localparam logic [2:0] PAL_BYTES_RESET = PAL_ARGB_BYTES;

  // rec.709 luma weights in 16-bit fixed point
  localparam logic [15:0] LUMA_G = 16'd46885;
  localparam logic [15:0] LUMA_B = 16'd4725;
  localparam logic [15:0] LUMA_R = 16'd13926;

  typedef struct packed {
    logic        command;
    logic [7:0]  palette_index;
    logic [31:0] palette_word;
    logic [31:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        format_error;
  } out_item_t;

  typedef struct packed {
    logic [3:0] source_format;
    logic [3:0] target_format;
    logic [2:0] palette_entry_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] a;
  } channels_t;

  // widening tables for fields whose max is not a divisor-friendly value
  typedef logic [7:0] widen3_table_t [8];
  typedef logic [7:0] widen5_table_t [32];
  typedef logic [7:0] widen6_table_t [64];

  function automatic widen3_table_t build_widen3();
    widen3_table_t t;
    for (int i = 0; i < 8; i++) begin
      t[i] = 8'((i * 255) / 7);
    end
    return t;
  endfunction

  function automatic widen5_table_t build_widen5();
    widen5_table_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255) / 31);
    end
    return t;
  endfunction

  function automatic widen6_table_t build_widen6();
    widen6_table_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255) / 63);
    end
    return t;
  endfunction

  localparam widen3_table_t WIDEN3 = build_widen3();
  localparam widen5_table_t WIDEN5 = build_widen5();
  localparam widen6_table_t WIDEN6 = build_widen6();

endpackage

FILE: hw/rtl/pfc_ram.sv
// generic single-write, single-read ram with registered read data
module pfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/pfc_unpack.sv
// unpacks a source pixel or palette entry into 8-bit b, g, r, a channels
module pfc_unpack (
  input  pfc_pkg::cfg_t      cfg,
  input  logic [31:0]        pixel,
  input  logic [31:0]        entry,
  output pfc_pkg::channels_t ch,
  output logic               error
);

  logic [15:0] h;
  logic [7:0]  l;

  assign h = pixel[15:0];
  assign l = pixel[7:0];

  always_comb begin
    ch    = '0;
    error = 1'b0;
    unique case (cfg.source_format)
      pfc_pkg::FMT_A8R8G8B8, pfc_pkg::FMT_X8R8G8B8: begin
        ch.b = pixel[7:0];
        ch.g = pixel[15:8];
        ch.r = pixel[23:16];
        ch.a = pixel[31:24];
      end
      pfc_pkg::FMT_R8G8B8: begin
        ch.b = pixel[7:0];
        ch.g = pixel[15:8];
        ch.r = pixel[23:16];
        ch.a = 8'hFF;
      end
      pfc_pkg::FMT_A4R4G4B4: begin
        // 4-bit field times 17 is the same as repeating the nibble
        ch.a = {h[15:12], h[15:12]};
        ch.r = {h[11:8], h[11:8]};
        ch.g = {h[7:4], h[7:4]};
        ch.b = {h[3:0], h[3:0]};
      end
      pfc_pkg::FMT_R5G6B5: begin
        ch.r = pfc_pkg::WIDEN5[h[15:11]];
        ch.g = pfc_pkg::WIDEN6[h[10:5]];
        ch.b = pfc_pkg::WIDEN5[h[4:0]];
        ch.a = 8'hFF;
      end
      pfc_pkg::FMT_A1R5G5B5: begin
        ch.a = {8{h[15]}};
        ch.r = pfc_pkg::WIDEN5[h[14:10]];
        ch.g = pfc_pkg::WIDEN5[h[9:5]];
        ch.b = pfc_pkg::WIDEN5[h[4:0]];
      end
      pfc_pkg::FMT_R3G3B2: begin
        ch.r = pfc_pkg::WIDEN3[l[7:5]];
        ch.g = pfc_pkg::WIDEN3[l[4:2]];
        ch.b = {4{l[1:0]}};
        ch.a = 8'hFF;
      end
      pfc_pkg::FMT_L8: begin
        ch.b = l;
        ch.g = l;
        ch.r = l;
        ch.a = 8'hFF;
      end
      pfc_pkg::FMT_A8: begin
        ch.a = l;
      end
      pfc_pkg::FMT_P8: begin
        if (cfg.palette_entry_bytes == pfc_pkg::PAL_RGB_BYTES) begin
          ch.r = entry[7:0];
          ch.g = entry[15:8];
          ch.b = entry[23:16];
          ch.a = 8'hFF;
        end else if (cfg.palette_entry_bytes == pfc_pkg::PAL_ARGB_BYTES) begin
          ch.a = entry[7:0];
          ch.r = entry[15:8];
          ch.g = entry[23:16];
          ch.b = entry[31:24];
        end else begin
          error = 1'b1;
        end
      end
      default: begin
        error = 1'b1;
      end
    endcase
  end

endmodule

FILE: hw/rtl/pfc_pack.sv
// repacks channels into the target format, with luma and same-format copy
module pfc_pack (
  input  pfc_pkg::cfg_t      cfg,
  input  pfc_pkg::channels_t ch,
  input  logic [31:0]        pixel,
  input  logic               src_error,
  output pfc_pkg::out_item_t item
);

  logic [23:0] luma_sum;
  logic [31:0] packed_px;
  logic [31:0] copy_px;
  logic        tgt_error;

  assign luma_sum = 24'(ch.g) * 24'(pfc_pkg::LUMA_G)
                  + 24'(ch.b) * 24'(pfc_pkg::LUMA_B)
                  + 24'(ch.r) * 24'(pfc_pkg::LUMA_R);

  always_comb begin
    packed_px = '0;
    copy_px   = '0;
    tgt_error = 1'b0;
    unique case (cfg.target_format)
      pfc_pkg::FMT_A8R8G8B8, pfc_pkg::FMT_X8R8G8B8: begin
        packed_px = {ch.a, ch.r, ch.g, ch.b};
        copy_px   = pixel;
      end
      pfc_pkg::FMT_R8G8B8: begin
        packed_px = {8'h00, ch.r, ch.g, ch.b};
        copy_px   = {8'h00, pixel[23:0]};
      end
      pfc_pkg::FMT_A4R4G4B4: begin
        packed_px = {16'h0000, ch.a[7:4], ch.r[7:4], ch.g[7:4], ch.b[7:4]};
        copy_px   = {16'h0000, pixel[15:0]};
      end
      pfc_pkg::FMT_A1R5G5B5: begin
        packed_px = {16'h0000, (ch.a != 8'h00), ch.r[7:3], ch.g[7:3], ch.b[7:3]};
        copy_px   = {16'h0000, pixel[15:0]};
      end
      pfc_pkg::FMT_R5G6B5: begin
        packed_px = {16'h0000, ch.r[7:3], ch.g[7:2], ch.b[7:3]};
        copy_px   = {16'h0000, pixel[15:0]};
      end
      pfc_pkg::FMT_R3G3B2: begin
        packed_px = {24'h000000, ch.r[7:5], ch.g[7:5], ch.b[7:6]};
        copy_px   = {24'h000000, pixel[7:0]};
      end
      pfc_pkg::FMT_L8: begin
        packed_px = {24'h000000, luma_sum[23:16]};
        copy_px   = {24'h000000, pixel[7:0]};
      end
      pfc_pkg::FMT_A8: begin
        packed_px = {24'h000000, ch.a};
        copy_px   = {24'h000000, pixel[7:0]};
      end
      default: begin
        // p8 and undefined codes cannot be produced
        tgt_error = 1'b1;
      end
    endcase

    item.format_error = src_error | tgt_error;
    if (item.format_error) begin
      item.pixel_out = '0;
    end else if (cfg.source_format == cfg.target_format) begin
      item.pixel_out = copy_px;
    end else begin
      item.pixel_out = packed_px;
    end
  end

endmodule

FILE: hw/rtl/pixel_format_converter.sv
// pixel format converter: three-stage pixel pipeline with palette ram
//
// Input channel (in_valid/in_stall/in_data) carries one beat per item: a
// convert beat turns pixel_in into one output beat, a palette write beat
// stores palette_word at palette_index and produces no output beat.
// Output channel (out_valid/out_stall/out_data) returns pixel_out and
// format_error in input order. Config channel (cfg_valid/cfg_ready) writes
// source_format, target_format and palette_entry_bytes by cfg_index; it is
// always ready and must only be used while no convert is in flight.
// Each beat passes through the stage registers in order: palette read
// (stage 1), unpack (stage 2) and pack/luma into the output register
// (stage 3); throughput is one beat per cycle while out_stall is low.
// A palette write is visible to a convert accepted on the next cycle.
// When out_stall is high the stages keep filling behind the held output
// register; in_stall rises only once all three stages hold a beat.
// Synchronous reset empties the pipeline and restores the config defaults;
// palette contents are undefined until written.
module pixel_format_converter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pfc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pfc_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pfc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  pfc_pkg::cfg_t cfg;

  logic in_accept;
  logic adv1;
  logic adv2;
  logic adv3;
  logic rd_en;
  logic wr_en;

  logic        s1_valid;
  logic [31:0] s1_pixel;
  logic        s1_oob;
  logic [31:0] pal_rd_data;
  logic [31:0] pal_entry;

  pfc_pkg::channels_t unpack_ch;
  logic               unpack_err;

  logic               s2_valid;
  pfc_pkg::channels_t s2_ch;
  logic               s2_err;
  logic [31:0]        s2_pixel;

  pfc_pkg::out_item_t pack_item;

  logic               s3_valid;
  pfc_pkg::out_item_t s3_item;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_format       <= pfc_pkg::FMT_A8R8G8B8;
      cfg.target_format       <= pfc_pkg::FMT_A8R8G8B8;
      cfg.palette_entry_bytes <= pfc_pkg::PAL_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pfc_pkg::CFG_SOURCE_FORMAT:       cfg.source_format <= cfg_data[3:0];
        pfc_pkg::CFG_TARGET_FORMAT:       cfg.target_format <= cfg_data[3:0];
        pfc_pkg::CFG_PALETTE_ENTRY_BYTES: cfg.palette_entry_bytes <= cfg_data[2:0];
        default: begin
          // unused index, write ignored
        end
      endcase
    end
  end

  // pipeline flow control
  assign adv3      = !s3_valid || !out_stall;
  assign adv2      = !s2_valid || adv3;
  assign adv1      = !s1_valid || adv2;
  assign in_stall  = !adv1;
  assign in_accept = in_valid && !in_stall;

  assign wr_en = in_accept && (in_data.command == pfc_pkg::CMD_WRITE_PALETTE)
              && (9'(in_data.palette_index) < 9'(pfc_pkg::PALETTE_DEPTH));
  assign rd_en = in_accept && (in_data.command == pfc_pkg::CMD_CONVERT);

  pfc_ram #(
    .WIDTH(32),
    .DEPTH(pfc_pkg::PALETTE_DEPTH)
  ) u_palette (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(in_data.palette_index[pfc_pkg::PAL_ADDR_W-1:0]),
    .wr_data(in_data.palette_word),
    .rd_en  (rd_en),
    .rd_addr(in_data.pixel_in[pfc_pkg::PAL_ADDR_W-1:0]),
    .rd_data(pal_rd_data)
  );

  // stage 1: pixel alongside the palette read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_pixel <= in_data.pixel_in;
      s1_oob   <= 9'(in_data.pixel_in[7:0]) >= 9'(pfc_pkg::PALETTE_DEPTH);
    end
  end

  // an index beyond the palette reads as zero
  assign pal_entry = s1_oob ? 32'h0 : pal_rd_data;

  pfc_unpack u_unpack (
    .cfg  (cfg),
    .pixel(s1_pixel),
    .entry(pal_entry),
    .ch   (unpack_ch),
    .error(unpack_err)
  );

  // stage 2: unpacked channels
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      s2_ch    <= unpack_ch;
      s2_err   <= unpack_err;
      s2_pixel <= s1_pixel;
    end
  end

  pfc_pack u_pack (
    .cfg      (cfg),
    .ch       (s2_ch),
    .pixel    (s2_pixel),
    .src_error(s2_err),
    .item     (pack_item)
  );

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_valid) begin
      s3_item <= pack_item;
    end
  end

  assign out_valid = s3_valid;
  assign out_data  = s3_item;

`include "pixel_format_converter_assert.svh"

  `PFC_ASSERT_IMP(a_error_zero, s3_valid && s3_item.format_error, s3_item.pixel_out == 32'h0, "error beat with nonzero pixel")
  `PFC_ASSERT_NXT(a_write_no_result, in_accept && (in_data.command == pfc_pkg::CMD_WRITE_PALETTE), !s1_valid, "palette write entered the pixel pipeline")
  `PFC_ASSERT_NXT(a_stage2_held, s2_valid && s3_valid && out_stall, s2_valid, "stage 2 beat lost while output stalled")
  `PFC_ASSERT_IMP(a_stall_only_full, in_stall, s1_valid && s2_valid && s3_valid, "input stalled with a free stage")

endmodule

FILE: tb/sv/pixel_format_converter_checker.sv
// pixel format converter checker: predicts each converted pixel and compares
`timescale 1ns / 100ps

module pfc_checker
  import pfc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  out_item_t              out_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     backlog
);

  logic [3:0]  src_fmt;
  logic [3:0]  tgt_fmt;
  logic [2:0]  pal_bytes;
  logic [31:0] pal_mem [PALETTE_DEPTH];
  out_item_t   expected_pixels [$];
  int          bad_total = 0;

  // n-bit field to 8 bits as v*255/(2^n-1), truncating
  function automatic logic [7:0] stretch(input logic [7:0] v, input int bits);
    int unsigned mx;
    mx = (1 << bits) - 1;
    return 8'((int'(v) * 255) / mx);
  endfunction

  function automatic logic [31:0] byte_mask(input logic [3:0] f);
    case (f)
      FMT_A8R8G8B8, FMT_X8R8G8B8: return 32'hFFFF_FFFF;
      FMT_R8G8B8: return 32'h00FF_FFFF;
      FMT_A4R4G4B4, FMT_R5G6B5, FMT_A1R5G5B5: return 32'h0000_FFFF;
      default: return 32'h0000_00FF;
    endcase
  endfunction

  function automatic out_item_t convert_pixel(input logic [31:0] px);
    out_item_t   res;
    logic [7:0]  b, g, r, a;
    logic [31:0] entry;
    int unsigned luma;
    logic        ok;
    res = '0;
    b = '0;
    g = '0;
    r = '0;
    a = '0;
    ok = 1'b1;
    entry = pal_mem[px[7:0]];
    case (src_fmt)
      FMT_A8R8G8B8, FMT_X8R8G8B8: {a, r, g, b} = px;
      FMT_R8G8B8: begin
        {r, g, b} = px[23:0];
        a = 8'hFF;
      end
      FMT_A4R4G4B4: begin
        a = stretch(px[15:12], 4);
        r = stretch(px[11:8], 4);
        g = stretch(px[7:4], 4);
        b = stretch(px[3:0], 4);
      end
      FMT_R5G6B5: begin
        r = stretch(px[15:11], 5);
        g = stretch(px[10:5], 6);
        b = stretch(px[4:0], 5);
        a = 8'hFF;
      end
      FMT_A1R5G5B5: begin
        a = stretch(px[15], 1);
        r = stretch(px[14:10], 5);
        g = stretch(px[9:5], 5);
        b = stretch(px[4:0], 5);
      end
      FMT_R3G3B2: begin
        r = stretch(px[7:5], 3);
        g = stretch(px[4:2], 3);
        b = stretch(px[1:0], 2);
        a = 8'hFF;
      end
      FMT_L8: begin
        b = px[7:0];
        g = px[7:0];
        r = px[7:0];
        a = 8'hFF;
      end
      FMT_A8: a = px[7:0];
      FMT_P8: begin
        // entry bytes in memory order, first byte lowest
        if (pal_bytes == PAL_RGB_BYTES) begin
          {b, g, r} = entry[23:0];
          a = 8'hFF;
        end else if (pal_bytes == PAL_ARGB_BYTES) begin
          {b, g, r, a} = entry;
        end else begin
          ok = 1'b0;
        end
      end
      default: ok = 1'b0;
    endcase
    if (tgt_fmt >= FMT_P8) ok = 1'b0;
    if (!ok) begin
      res.format_error = 1'b1;
      return res;
    end
    if (src_fmt == tgt_fmt) begin
      res.pixel_out = px & byte_mask(tgt_fmt);
      return res;
    end
    case (tgt_fmt)
      FMT_A8R8G8B8, FMT_X8R8G8B8: res.pixel_out = {a, r, g, b};
      FMT_R8G8B8: res.pixel_out = {8'h00, r, g, b};
      FMT_A4R4G4B4: res.pixel_out = {16'h0, a[7:4], r[7:4], g[7:4], b[7:4]};
      FMT_A1R5G5B5: res.pixel_out = {16'h0, a != 8'h00, r[7:3], g[7:3], b[7:3]};
      FMT_R5G6B5: res.pixel_out = {16'h0, r[7:3], g[7:2], b[7:3]};
      FMT_R3G3B2: res.pixel_out = {24'h0, r[7:5], g[7:5], b[7:6]};
      FMT_L8: begin
        luma = (32'(LUMA_G) * g + 32'(LUMA_B) * b + 32'(LUMA_R) * r) >> 16;
        res.pixel_out = {24'h0, luma[7:0]};
      end
      default: res.pixel_out = {24'h0, a};
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      src_fmt = FMT_A8R8G8B8;
      tgt_fmt = FMT_A8R8G8B8;
      pal_bytes = PAL_BYTES_RESET;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SOURCE_FORMAT: src_fmt = cfg_data;
          CFG_TARGET_FORMAT: tgt_fmt = cfg_data;
          CFG_PALETTE_ENTRY_BYTES: pal_bytes = cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_data.command == CMD_WRITE_PALETTE) begin
          pal_mem[in_data.palette_index] = in_data.palette_word;
        end else begin
          expected_pixels.push_back(convert_pixel(in_data.pixel_in));
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          if (bad_total < 10)
            $display("unexpected output beat: pixel_out %h format_error %b",
                     out_data.pixel_out, out_data.format_error);
          bad_total++;
        end else begin
          want = expected_pixels.pop_front();
          if (want.pixel_out !== out_data.pixel_out ||
              want.format_error !== out_data.format_error) begin
            if (bad_total < 10)
              $display("pixel mismatch: expected %h/%b got %h/%b",
                       want.pixel_out, want.format_error,
                       out_data.pixel_out, out_data.format_error);
            bad_total++;
          end
        end
      end
    end
    mismatches <= bad_total;
    backlog <= expected_pixels.size();
  end

endmodule

FILE: tb/sv/testbench.sv
// testbench top for the pixel format converter: stimulus, idling and verdict
`timescale 1ns / 100ps

module testbench;
  import pfc_pkg::*;

  localparam int PHASES          = 28;
  localparam int BEATS_PER_PHASE = 25;
  localparam int LAT_WAIT        = 8;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     mismatches;
  int                     backlog;

  int gap_pct = 0;
  int stall_pct = 0;
  bit pal_seen [PALETTE_DEPTH];
  logic [7:0] pal_used [$];

  pixel_format_converter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pfc_checker pixel_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    #2_000_000;
    $display("[pixel_format_converter] ERROR");
    $finish;
  end

  task automatic send_beat(input in_item_t it);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic convert(input logic [31:0] px);
    in_item_t it;
    it.command = CMD_CONVERT;
    it.palette_index = 8'($urandom);
    it.palette_word = $urandom;
    it.pixel_in = px;
    send_beat(it);
  endtask

  task automatic write_palette(input logic [7:0] idx, input logic [31:0] word);
    in_item_t it;
    it.command = CMD_WRITE_PALETTE;
    it.palette_index = idx;
    it.palette_word = word;
    it.pixel_in = $urandom;
    if (!pal_seen[idx]) begin
      pal_seen[idx] = 1'b1;
      pal_used.push_back(idx);
    end
    send_beat(it);
  endtask

  // hold the sender until every pending pixel is out and the pipe is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_formats(input logic [3:0] src, input logic [3:0] tgt,
                             input logic [3:0] pebd);
    wait_drained();
    write_reg(CFG_SOURCE_FORMAT, src);
    write_reg(CFG_TARGET_FORMAT, tgt);
    write_reg(CFG_PALETTE_ENTRY_BYTES, pebd);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_case(input logic [3:0] src, input logic [3:0] tgt,
                            input logic [3:0] pebd, input logic [31:0] px);
    set_formats(src, tgt, pebd);
    convert(px);
  endtask

  // P8 pixels only ever index entries that have been loaded
  function automatic logic [31:0] random_pixel(input logic [3:0] src);
    logic [31:0] px;
    px = $urandom;
    case ($urandom_range(0, 9))
      0: px = '0;
      1: px = '1;
      default: ;
    endcase
    if (src == FMT_P8) px[7:0] = pal_used[$urandom_range(0, pal_used.size() - 1)];
    return px;
  endfunction

  initial begin : stimulus
    logic [3:0] src_sel;
    logic [3:0] tgt_sel;
    logic [2:0] peb_sel;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config is an identity copy
    convert(32'hFFFF_FFFF);
    convert(32'h0000_0000);
    write_palette(8'h00, 32'h1234_5678);
    write_palette(8'hFF, 32'hFFFF_FFFF);
    write_palette(8'h80, 32'h0000_0000);

    check_case(FMT_P8, FMT_A8R8G8B8, 4'(PAL_ARGB_BYTES), 32'hFFFF_FF00);
    convert(32'h0000_00FF);
    check_case(FMT_P8, FMT_A8R8G8B8, 4'(PAL_RGB_BYTES), 32'h0000_0000);
    check_case(FMT_P8, FMT_R8G8B8, 4'h0, 32'h0000_00FF);
    check_case(FMT_P8, FMT_A8R8G8B8, 4'hF, 32'h0000_0080);
    check_case(4'hF, FMT_A8R8G8B8, 4'(PAL_ARGB_BYTES), 32'hFFFF_FFFF);
    check_case(FMT_A8R8G8B8, FMT_P8, 4'(PAL_ARGB_BYTES), 32'hFFFF_FFFF);
    check_case(FMT_A8R8G8B8, 4'hF, 4'(PAL_ARGB_BYTES), 32'hFFFF_FFFF);
    check_case(FMT_A4R4G4B4, FMT_A8R8G8B8, 4'(PAL_ARGB_BYTES), 32'hFFFF_A5C3);
    check_case(FMT_R5G6B5, FMT_A8R8G8B8, 4'(PAL_ARGB_BYTES), 32'h0000_F81F);
    check_case(FMT_A1R5G5B5, FMT_X8R8G8B8, 4'(PAL_ARGB_BYTES), 32'h0000_8000);
    check_case(FMT_R3G3B2, FMT_R8G8B8, 4'(PAL_ARGB_BYTES), 32'h0000_00FF);
    check_case(FMT_L8, FMT_A8R8G8B8, 4'(PAL_ARGB_BYTES), 32'h0000_0080);
    check_case(FMT_A8, FMT_A8R8G8B8, 4'(PAL_ARGB_BYTES), 32'h0000_00FF);
    check_case(FMT_A8R8G8B8, FMT_L8, 4'(PAL_ARGB_BYTES), 32'hFFFF_FFFF);
    check_case(FMT_A8R8G8B8, FMT_A8, 4'(PAL_ARGB_BYTES), 32'h8000_0000);
    check_case(FMT_X8R8G8B8, FMT_R3G3B2, 4'(PAL_ARGB_BYTES), 32'h1234_5678);
    check_case(FMT_A8R8G8B8, FMT_R5G6B5, 4'(PAL_ARGB_BYTES), 32'h00FF_FFFF);
    check_case(FMT_A8R8G8B8, FMT_A1R5G5B5, 4'(PAL_ARGB_BYTES), 32'h00FF_FFFF);
    check_case(FMT_A8R8G8B8, FMT_A4R4G4B4, 4'(PAL_ARGB_BYTES), 32'hF0FF_8000);
    check_case(FMT_X8R8G8B8, FMT_A8R8G8B8, 4'(PAL_ARGB_BYTES), 32'hAB00_0000);
    // same format drops the unused high byte
    check_case(FMT_R8G8B8, FMT_R8G8B8, 4'(PAL_ARGB_BYTES), 32'hAA12_3456);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 52; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 52; end
        default: begin gap_pct = 27; stall_pct <= 27; end
      endcase
      src_sel = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                            : 4'($urandom_range(0, 9));
      tgt_sel = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
      if ($urandom_range(0, 6) == 0) tgt_sel = src_sel;
      peb_sel = 3'($urandom_range(0, 7));
      if (src_sel == FMT_P8 && $urandom_range(0, 4) != 0)
        peb_sel = $urandom_range(0, 1) ? PAL_RGB_BYTES : PAL_ARGB_BYTES;
      set_formats(src_sel, tgt_sel, {1'($urandom_range(0, 1)), peb_sel});
      repeat (BEATS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 20) write_palette(8'($urandom), $urandom);
        else convert(random_pixel(src_sel));
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("[pixel_format_converter] OK");
    end else begin
      $display("[pixel_format_converter] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_ram.sv
hw/rtl/pfc_unpack.sv
hw/rtl/pfc_pack.sv
hw/rtl/pixel_format_converter.sv
tb/sv/pixel_format_converter_checker.sv
tb/sv/testbench.sv
